// File: sv/aes_ctr_pkg.sv
// Shared types, constants and AES helper functions for the AES-128 CTR core.
// No dependencies.
package aes_ctr_pkg;

	localparam int unsigned NUM_ROUNDS = 10;

	typedef logic [127:0] block_t;
	typedef logic [7:0]   byte_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_NONCE    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] pt_low;
		logic [63:0] pt_high;
		logic [4:0]  valid_bytes;
	} side_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t RCON [NUM_ROUNDS] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of the state sits at bits [8i+7:8i].
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		byte_t a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = s[32*c +: 8];
			a1 = s[32*c+8 +: 8];
			a2 = s[32*c+16 +: 8];
			a3 = s[32*c+24 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
			t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
			t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// One key-schedule step: next round key from the previous one.
	function automatic block_t next_key(input block_t k, input byte_t rc);
		block_t n;
		logic [31:0] t;
		t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
		     SBOX[k[111:104]] ^ rc};
		n[31:0]   = k[31:0] ^ t;
		n[63:32]  = k[63:32] ^ n[31:0];
		n[95:64]  = k[95:64] ^ n[63:32];
		n[127:96] = k[127:96] ^ n[95:64];
		return n;
	endfunction

endpackage

// File: sv/aes_ctr_round.sv
// One registered AES round stage with its own key-schedule step.
// Depends on aes_ctr_pkg.
module aes_ctr_round import aes_ctr_pkg::*; #(
	parameter int unsigned ROUND = 1
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  block_t in_state,
	input  block_t in_key,
	input  side_t  in_side,
	output logic   out_valid,
	output block_t out_state,
	output block_t out_key,
	output side_t  out_side
);
	block_t key_nx;
	block_t st_nx;

	always_comb begin
		key_nx = next_key(in_key, RCON[ROUND-1]);
		if (ROUND == NUM_ROUNDS)
			st_nx = sub_shift(in_state) ^ key_nx;
		else
			st_nx = mix_columns(sub_shift(in_state)) ^ key_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_state <= st_nx;
			out_key   <= key_nx;
			out_side  <= in_side;
		end
	end
endmodule

// File: sv/aes128_ctr_block_cipher_core.sv
// Top level of the AES-128 counter-mode core: config registers, pipeline, output mask.
// Depends on aes_ctr_pkg and aes_ctr_round.
//
// Usage:
//  - cfg channel: cfg_valid/cfg_ready with cfg_index (0 key_low, 1 key_high,
//    2 nonce, others dropped) and cfg_data. Write only while the core is idle.
//  - s_axis: one beat per 16-byte block; tdata packs pt_low, pt_high,
//    block_index, valid_bytes. m_axis: one beat per block, ct_low, ct_high.
//  - Pipeline: twelve register stages (initial key add, ten rounds, mask); the
//    key add stage loads at the edge that accepts an input beat.
//  - Throughput: one block per cycle unless the receiver stalls; each round owns
//    its own S-box logic and key-schedule step, so blocks stream back to back.
//  - Stall: the whole pipeline advances only when the output register is empty
//    or being taken, so a stalled receiver holds every stage; nothing is lost.
//  - Reset: clears all valid bits and the key and nonce to zero.
module aes128_ctr_block_cipher_core import aes_ctr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [199:0] s_axis_tdata,  // pt_low, pt_high, block_index, valid_bytes, zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // ct_low, ct_high
);
	logic [63:0] key_low_q, key_high_q, nonce_q;
	logic        en;

	logic   v [NUM_ROUNDS+1];
	block_t st [NUM_ROUNDS+1];
	block_t ky [NUM_ROUNDS+1];
	side_t  sd [NUM_ROUNDS+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			nonce_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_NONCE:    nonce_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance everything unless the output holds a beat that is not taken.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 0: counter block XOR round key 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v[0] <= 1'b0;
		else if (en)
			v[0] <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= {s_axis_tdata[191:128], nonce_q} ^ {key_high_q, key_low_q};
			ky[0] <= {key_high_q, key_low_q};
			sd[0] <= side_t'({s_axis_tdata[63:0], s_axis_tdata[127:64],
				s_axis_tdata[196:192]});
		end
	end

	for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
		aes_ctr_round #(.ROUND(r)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v[r-1]),
			.in_state (st[r-1]),
			.in_key   (ky[r-1]),
			.in_side  (sd[r-1]),
			.out_valid(v[r]),
			.out_state(st[r]),
			.out_key  (ky[r]),
			.out_side (sd[r])
		);
	end

	// Output stage: XOR keystream into plaintext and zero bytes past the count.
	block_t ks_ct;
	block_t mask;
	always_comb begin
		ks_ct = st[NUM_ROUNDS] ^ {sd[NUM_ROUNDS].pt_high, sd[NUM_ROUNDS].pt_low};
		for (int i = 0; i < 16; i++)
			mask[8*i +: 8] = (5'(i) < sd[NUM_ROUNDS].valid_bytes) ? 8'hff : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (en)
			m_axis_tvalid <= v[NUM_ROUNDS];
	end

	always_ff @(posedge clk) begin
		if (en)
			m_axis_tdata <= ks_ct & mask;
	end
endmodule

// File: bench/aes128_ctr_block_cipher_core_test.sv
// Self-checking bench for the AES-128 counter-mode core: drives blocks and key/nonce
// writes, predicts each ciphertext beat with a local AES model. Depends on aes_ctr_pkg.
`timescale 1ns / 1ps
module aes128_ctr_block_cipher_core_test;
	import aes_ctr_pkg::*;

	// Last member sits in the lowest bits, matching the tdata layout.
	typedef struct packed {
		logic [4:0]  valid_bytes;
		logic [63:0] block_index;
		logic [63:0] pt_high;
		logic [63:0] pt_low;
	} ctr_beat_t;

	typedef struct packed {
		logic [63:0] ct_high;
		logic [63:0] ct_low;
	} ct_beat_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata;  // pt_low, pt_high, block_index, valid_bytes, zero pad
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;  // ct_low, ct_high

	aes128_ctr_block_cipher_core dut (.*);

	// Local copy of the key, nonce and round keys.
	logic [63:0] key_lo_q, key_hi_q, nonce_q;
	logic [7:0]  sub_tab [256];
	logic [7:0]  rc_tab [10];
	logic [7:0]  rkey [11][16];

	ctr_beat_t pending_blocks [$];
	ct_beat_t  expected_ct [$];
	int        failures;

	function automatic logic [7:0] gmul2(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic rebuild_round_keys();
		logic [7:0] w [176];
		logic [7:0] t [4];
		logic [7:0] t0;
		for (int i = 0; i < 8; i++) begin
			w[i] = key_lo_q[8*i +: 8];
			w[8+i] = key_hi_q[8*i +: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
			if (i % 4 == 0) begin
				t0 = t[0];
				t[0] = sub_tab[t[1]] ^ rc_tab[i/4-1];
				t[1] = sub_tab[t[2]];
				t[2] = sub_tab[t[3]];
				t[3] = sub_tab[t0];
			end
			for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ t[j];
		end
		for (int r = 0; r < 11; r++)
			for (int b = 0; b < 16; b++) rkey[r][b] = w[16*r+b];
	endtask

	function automatic ct_beat_t ctr_encrypt(ctr_beat_t it);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] ks, mask;
		int v;
		ct_beat_t r;
		for (int i = 0; i < 8; i++) begin
			s[i] = nonce_q[8*i +: 8];
			s[8+i] = it.block_index[8*i +: 8];
		end
		for (int i = 0; i < 16; i++) s[i] ^= rkey[0][i];
		for (int rd = 1; rd <= 10; rd++) begin
			for (int c = 0; c < 4; c++)
				for (int rw = 0; rw < 4; rw++) t[rw+4*c] = sub_tab[s[rw+4*((c+rw)%4)]];
			s = t;
			if (rd < 10)
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					s[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
					s[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
					s[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
					s[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
				end
			for (int i = 0; i < 16; i++) s[i] ^= rkey[rd][i];
		end
		for (int i = 0; i < 16; i++) ks[8*i +: 8] = s[i];
		// Saturate counts above sixteen; bytes at or past the count read zero.
		v = (it.valid_bytes > 16) ? 16 : it.valid_bytes;
		mask = '0;
		for (int i = 0; i < 16; i++) if (i < v) mask[8*i +: 8] = 8'hff;
		ks = (ks ^ {it.pt_high, it.pt_low}) & mask;
		r.ct_low = ks[63:0];
		r.ct_high = ks[127:64];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("aes128_ctr_block_cipher_core: mismatch");
		$finish;
	end

	// Driver: hold valid across back-to-back beats, draw a gap per beat.
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_ct.push_back(ctr_encrypt(ctr_beat_t'(s_axis_tdata[196:0])));
				src_gap = $urandom_range(0, 11);
				if ($urandom_range(0, 3) == 0) src_gap = 0;
			end
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_blocks.size() > 0 &&
				!(s_axis_tvalid && !s_axis_tready)) begin
				s_axis_tdata <= {3'b000, pending_blocks.pop_front()};
				s_axis_tvalid <= 1'b1;
			end else if (s_axis_tvalid && s_axis_tready) begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure, compare each beat with the oldest prediction.
	int sink_gap;
	ct_beat_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = ct_beat_t'(m_axis_tdata);
				if (expected_ct.size() == 0) begin
					$error("ciphertext beat with none pending: %h", m_axis_tdata);
					failures++;
				end else begin
					want = expected_ct.pop_front();
					if (got.ct_low !== want.ct_low) begin
						$error("ct_low expected %h actual %h", want.ct_low, got.ct_low);
						failures++;
					end
					if (got.ct_high !== want.ct_high) begin
						$error("ct_high expected %h actual %h", want.ct_high, got.ct_high);
						failures++;
					end
				end
				sink_gap = $urandom_range(0, 11);
				if ($urandom_range(0, 3) == 0) sink_gap = 0;
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_blocks.size() > 0 || s_axis_tvalid || expected_ct.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Write one register over the config channel and track it locally.
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KEY_LOW: begin key_lo_q = val; rebuild_round_keys(); end
			REG_KEY_HIGH: begin key_hi_q = val; rebuild_round_keys(); end
			REG_NONCE: nonce_q = val;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic ctr_beat_t rand_block();
		ctr_beat_t b;
		b.pt_low = rand64();
		b.pt_high = rand64();
		b.block_index = ($urandom_range(0, 1)) ? rand64() : 64'($urandom_range(0, 40));
		// Mostly legal counts, now and then zero or an oversize count.
		b.valid_bytes = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
		return b;
	endfunction

	initial begin
		ctr_beat_t b;
		for (int i = 0; i < 256; i++) sub_tab[i] = SBOX[i];
		for (int i = 0; i < 10; i++) rc_tab[i] = RCON[i];
		failures = 0;
		key_lo_q = '0;
		key_hi_q = '0;
		nonce_q = '0;
		rebuild_round_keys();
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_LOW;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset key, extremes of fields, zero and oversize counts.
		for (int v = 0; v <= 17; v++) begin
			b.pt_low = (v % 2) ? '1 : '0;
			b.pt_high = (v % 3) ? '1 : 64'h0123_4567_89ab_cdef;
			b.block_index = (v % 2) ? '1 : 64'(v);
			b.valid_bytes = 5'(v);
			pending_blocks.push_back(b);
		end
		b.valid_bytes = 5'd31;
		pending_blocks.push_back(b);
		wait_drained();

		// Sender hold-off: all results back before writing the key extremes.
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_NONCE, '1);
		for (int i = 0; i < 4; i++) pending_blocks.push_back(rand_block());
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_KEY_LOW, rand64());
			write_reg(REG_KEY_HIGH, rand64());
			write_reg(REG_NONCE, (ph == 5) ? 64'd0 : rand64());
			for (int i = 0; i < 90; i++) pending_blocks.push_back(rand_block());
			wait_drained();
		end

		if (failures == 0) begin
			$display("aes128_ctr_block_cipher_core: match");
		end else begin
			$display("aes128_ctr_block_cipher_core: mismatch");
		end
		$finish;
	end
endmodule

// File: sim.f
sv/aes_ctr_pkg.sv
sv/aes_ctr_round.sv
sv/aes128_ctr_block_cipher_core.sv
bench/aes128_ctr_block_cipher_core_test.sv
